@@ design/random_fern_code_encoder_macros.svh @@
// ---------------------------------------------------------------------------
// Fern code encoder assertion macros
// Shared property wrappers, clocked on clk and disabled during arst_n.
// ---------------------------------------------------------------------------
`ifndef RANDOM_FERN_CODE_ENCODER_MACROS_SVH
`define RANDOM_FERN_CODE_ENCODER_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define RFCE_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rfce invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define RFCE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rfce implication violated");

`endif

@@ design/rfce_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fern code encoder package
// Sizes, field widths, codes and shared types of the encoder.
// ---------------------------------------------------------------------------
package rfce_pkg;

	localparam int MAX_FERNS     = 512;
	localparam int MAX_DECISIONS = 8;
	localparam int PIXEL_DEPTH   = 16384;
	localparam int TABLE_DEPTH   = MAX_FERNS * MAX_DECISIONS;

	localparam int TAB_AW = $clog2(TABLE_DEPTH);
	localparam int PIX_AW = $clog2(PIXEL_DEPTH);
	localparam int DEC_CW = $clog2(MAX_DECISIONS + 1);
	localparam int DEC_IW = (MAX_DECISIONS > 1) ? $clog2(MAX_DECISIONS) : 1;

	// transaction field widths
	localparam int CMD_W   = 2;
	localparam int SLOT_W  = 12;
	localparam int LOC_W   = 7;
	localparam int LEVEL_W = 16;
	localparam int PADDR_W = 14;
	localparam int FERN_W  = 9;
	localparam int CODE_W  = 8;

	// configuration register widths
	localparam int FCNT_W = 10;
	localparam int NDEC_W = 4;
	localparam int IMGW_W = 8;
	localparam int CFG_DW = 10;
	localparam int CFG_IW = 2;

	localparam int ITEM_AW_A = (SLOT_W > PADDR_W) ? SLOT_W : PADDR_W;
	localparam int ITEM_AW   = (ITEM_AW_A > FERN_W) ? ITEM_AW_A : FERN_W;
	localparam int BASE_W    = FERN_W + DEC_CW;
	localparam int IDX_W     = (BASE_W + 1 > TAB_AW) ? BASE_W + 1 : TAB_AW;
	localparam int PROD_W    = LOC_W + IMGW_W;
	localparam int PCALC_W   = PROD_W + 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int Q_PW        = $clog2(QUEUE_DEPTH);

	localparam logic [CMD_W-1:0] CMD_TESTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PIXEL  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CODE   = 2'd2;

	localparam logic [CFG_IW-1:0] REG_FERN_COUNT  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_DECISIONS   = 2'd1;
	localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH = 2'd2;

	localparam logic [FCNT_W-1:0] FERN_COUNT_RST  = 10'd500;
	localparam logic [NDEC_W-1:0] DECISIONS_RST   = 4'd4;
	localparam logic [IMGW_W-1:0] IMAGE_WIDTH_RST = 8'd80;

	typedef enum logic [1:0] {
		OP_TESTER,
		OP_PIXEL,
		OP_CODE
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic [ITEM_AW-1:0]         addr;
		logic [LOC_W-1:0]           col;
		logic [LOC_W-1:0]           row;
		logic signed [LEVEL_W-1:0]  level;
	} item_t;

	typedef struct packed {
		logic [LOC_W-1:0]           col;
		logic [LOC_W-1:0]           row;
		logic signed [LEVEL_W-1:0]  level;
	} tester_t;

	typedef struct packed {
		logic [FCNT_W-1:0] fern_count;
		logic [NDEC_W-1:0] decisions;
		logic [IMGW_W-1:0] image_width;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_WALK,
		B_DRAIN
	} bstate_t;

endpackage

@@ design/rfce_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fern code encoder front end
// Accepts input transactions, drops unused or out-of-range ones, and hands
// the classified items to the queue through one register stage.
// ---------------------------------------------------------------------------
module rfce_front
	import rfce_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [CMD_W-1:0]           command,
	input  logic [SLOT_W-1:0]          tester_slot,
	input  logic [LOC_W-1:0]           loc_x,
	input  logic [LOC_W-1:0]           loc_y,
	input  logic signed [LEVEL_W-1:0]  test_level,
	input  logic [PADDR_W-1:0]         pixel_addr,
	input  logic signed [LEVEL_W-1:0]  pixel_value,
	input  logic [FERN_W-1:0]          fern_sel,
	output logic                       push,
	output item_t                      push_item,
	input  q_stat_t                    q_stat
);

	logic  accept;
	logic  keep;
	item_t item;
	logic  valid_s1;
	item_t item_s1;

	always_comb begin
		keep = 1'b0;
		item = '0;
		case (command)
			CMD_TESTER: begin
				keep       = 32'(tester_slot) < TABLE_DEPTH;
				item.op    = OP_TESTER;
				item.addr  = ITEM_AW'(tester_slot);
				item.col   = loc_x;
				item.row   = loc_y;
				item.level = test_level;
			end
			CMD_PIXEL: begin
				keep       = 32'(pixel_addr) < PIXEL_DEPTH;
				item.op    = OP_PIXEL;
				item.addr  = ITEM_AW'(pixel_addr);
				item.level = pixel_value;
			end
			CMD_CODE: begin
				keep      = 1'b1;
				item.op   = OP_CODE;
				item.addr = ITEM_AW'(fern_sel);
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign in_stall  = valid_s1 && q_stat.full;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && !q_stat.full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

endmodule

@@ design/rfce_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fern code encoder item queue
// Short FIFO between front end and back end.
// ---------------------------------------------------------------------------
module rfce_queue
	import rfce_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   head,
	output q_stat_t q_stat
);

	item_t           slot_q [QUEUE_DEPTH];
	logic [Q_PW-1:0] wp_q;
	logic [Q_PW-1:0] rp_q;
	logic [Q_PW:0]   cnt_q;

	assign head         = slot_q[rp_q];
	assign q_stat.full  = cnt_q == (Q_PW + 1)'(QUEUE_DEPTH);
	assign q_stat.empty = cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == Q_PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + Q_PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == Q_PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + Q_PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (Q_PW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (Q_PW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_item;
		end
	end

endmodule

@@ design/rfce_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fern code encoder back end
// Holds the tester table and pixel store, carries out writes and walks the
// testers of a requested fern through tester read, address and pixel read stages.
// ---------------------------------------------------------------------------
module rfce_back
	import rfce_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  q_stat_t            q_stat,
	input  item_t              head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [FERN_W-1:0]  fern_id,
	output logic [CODE_W-1:0]  fern_code
);

	bstate_t state_q;
	bstate_t state_d;

	logic issue;
	logic load_out;
	logic wr_tester;
	logic wr_pixel;
	logic start_req;
	logic start_walk;
	logic last_issue;
	logic pipe_empty;
	logic out_free;

	logic [FERN_W-1:0]        head_fern;
	logic [DEC_CW-1:0]        nd;
	logic [BASE_W-1:0]        base;
	logic [IDX_W-1:0]         idx;

	logic [FERN_W-1:0]        fern_q;
	logic [DEC_CW-1:0]        nd_q;
	logic [DEC_CW-1:0]        d_q;
	logic [BASE_W-1:0]        base_q;
	logic [MAX_DECISIONS-1:0] code_q;

	tester_t tester_mem [TABLE_DEPTH];
	logic signed [LEVEL_W-1:0] pixel_mem [PIXEL_DEPTH];

	logic                      valid_s1;
	logic                      ok_s1;
	logic [DEC_IW-1:0]         d_s1;
	tester_t                   tdata_s1;

	logic [PROD_W-1:0]         prod;
	logic [PCALC_W-1:0]        pcalc;

	logic                      valid_s2;
	logic                      ok_s2;
	logic [DEC_IW-1:0]         d_s2;
	logic [PCALC_W-1:0]        addr_s2;
	logic signed [LEVEL_W-1:0] level_s2;

	logic                      valid_s3;
	logic                      ok_s3;
	logic [DEC_IW-1:0]         d_s3;
	logic signed [LEVEL_W-1:0] pix_s3;
	logic signed [LEVEL_W-1:0] level_s3;

	logic                      out_valid_q;

	assign head_fern  = head.addr[FERN_W-1:0];
	assign nd         = (cfg.decisions > NDEC_W'(MAX_DECISIONS)) ?
	                    DEC_CW'(MAX_DECISIONS) : DEC_CW'(cfg.decisions);
	assign base       = BASE_W'(head_fern * nd);
	assign start_walk = (FCNT_W'(head_fern) < cfg.fern_count) && (nd != '0);
	assign idx        = IDX_W'(base_q) + IDX_W'(d_q);
	assign last_issue = (d_q + DEC_CW'(1)) == nd_q;
	assign pipe_empty = !valid_s1 && !valid_s2 && !valid_s3;
	assign out_free   = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_stat.empty && head.op == OP_CODE) begin
					state_d = start_walk ? B_WALK : B_DRAIN;
				end
			end
			B_WALK: begin
				if (last_issue) begin
					state_d = B_DRAIN;
				end
			end
			B_DRAIN: begin
				if (pipe_empty && out_free) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		pop      = 1'b0;
		issue    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			B_IDLE:  pop      = !q_stat.empty;
			B_WALK:  issue    = 1'b1;
			B_DRAIN: load_out = pipe_empty && out_free;
			default: pop      = 1'b0;
		endcase
	end

	assign wr_tester = pop && head.op == OP_TESTER;
	assign wr_pixel  = pop && head.op == OP_PIXEL;
	assign start_req = pop && head.op == OP_CODE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request bookkeeping and code accumulation
	always_ff @(posedge clk) begin
		if (start_req) begin
			fern_q <= head_fern;
			nd_q   <= nd;
			base_q <= base;
			d_q    <= '0;
			code_q <= '0;
		end else begin
			if (issue) begin
				d_q <= d_q + DEC_CW'(1);
			end
			if (valid_s3 && ok_s3 && pix_s3 >= level_s3) begin
				code_q[d_s3] <= 1'b1;
			end
		end
	end

	// tester table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_tester) begin
			tester_mem[TAB_AW'(head.addr)] <= '{head.col, head.row, head.level};
		end
		if (issue) begin
			tdata_s1 <= tester_mem[idx[TAB_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ok_s1 <= 32'(idx) < TABLE_DEPTH;
			d_s1  <= d_q[DEC_IW-1:0];
		end
	end

	assign prod  = tdata_s1.row * cfg.image_width;
	assign pcalc = PCALC_W'(prod) + PCALC_W'(tdata_s1.col);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ok_s2    <= ok_s1 && (32'(pcalc) < PIXEL_DEPTH);
			d_s2     <= d_s1;
			addr_s2  <= pcalc;
			level_s2 <= tdata_s1.level;
		end
	end

	// pixel store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_pixel) begin
			pixel_mem[PIX_AW'(head.addr)] <= head.level;
		end
		if (valid_s2) begin
			pix_s3 <= pixel_mem[addr_s2[PIX_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			ok_s3    <= ok_s2;
			d_s3     <= d_s2;
			level_s3 <= level_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			fern_id   <= fern_q;
			fern_code <= CODE_W'(code_q);
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ design/random_fern_code_encoder.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Random fern code encoder
// Tester table, pixel store and fern code generation.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one transaction per command:
//   write a tester, write a pixel, or request one fern's code. Unused
//   commands and out-of-range writes are dropped at the front end.
//   Output channel (out_valid/out_stall) returns fern_id and fern_code,
//   one transaction for each code request, in request order.
//   Writes are carried out as they leave the queue. A code request with N
//   decisions walks its testers with one tester read per cycle,
//   then the tester, address and pixel read stages drain before the
//   result is registered. Requests for an unused fern or with zero
//   decisions skip the walk. Between input and output, transactions
//   also pass through the front register.
//   A four-entry queue decouples the front end; while it has room,
//   transactions keep being accepted as the back end works or a result waits.
//   A stalled result holds back only the registering of the next result;
//   writes and walks proceed. Reset clears control state and restores the
//   configuration registers; table and store contents are undefined until
//   written. Write the configuration only while the block is idle.
// ---------------------------------------------------------------------------
`include "random_fern_code_encoder_macros.svh"

module random_fern_code_encoder
	import rfce_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_IW-1:0]          cfg_index,
	input  logic [CFG_DW-1:0]          cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [CMD_W-1:0]           command,
	input  logic [SLOT_W-1:0]          tester_slot,
	input  logic [LOC_W-1:0]           loc_x,
	input  logic [LOC_W-1:0]           loc_y,
	input  logic signed [LEVEL_W-1:0]  test_level,
	input  logic [PADDR_W-1:0]         pixel_addr,
	input  logic signed [LEVEL_W-1:0]  pixel_value,
	input  logic [FERN_W-1:0]          fern_sel,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [FERN_W-1:0]          fern_id,
	output logic [CODE_W-1:0]          fern_code
);

	cfg_t    cfg_q;
	logic    push;
	item_t   push_item;
	logic    pop;
	item_t   head;
	q_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fern_count  <= FERN_COUNT_RST;
			cfg_q.decisions   <= DECISIONS_RST;
			cfg_q.image_width <= IMAGE_WIDTH_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FERN_COUNT:  cfg_q.fern_count  <= FCNT_W'(cfg_data);
				REG_DECISIONS:   cfg_q.decisions   <= NDEC_W'(cfg_data);
				REG_IMAGE_WIDTH: cfg_q.image_width <= IMGW_W'(cfg_data);
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	rfce_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.tester_slot (tester_slot),
		.loc_x       (loc_x),
		.loc_y       (loc_y),
		.test_level  (test_level),
		.pixel_addr  (pixel_addr),
		.pixel_value (pixel_value),
		.fern_sel    (fern_sel),
		.push        (push),
		.push_item   (push_item),
		.q_stat      (q_stat)
	);

	rfce_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	rfce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.fern_id   (fern_id),
		.fern_code (fern_code)
	);

	`RFCE_ASSERT_ALWAYS(a_queue_status, !(q_stat.full && q_stat.empty))
	`RFCE_ASSERT_IMPL(a_pop_nonempty, pop, !q_stat.empty)
	`RFCE_ASSERT_IMPL(a_push_room, push, !q_stat.full)
	`RFCE_ASSERT_IMPL(a_stall_full, in_stall, q_stat.full)

endmodule

@@ test/fern_code_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fern code encoder checker
// Follows configuration writes and input transactions, predicts the code of
// each request from shadow tables and compares every output transaction.
// ---------------------------------------------------------------------------
module fern_code_checker
	import rfce_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_IW-1:0]         cfg_index,
	input  logic [CFG_DW-1:0]         cfg_data,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [CMD_W-1:0]          command,
	input  logic [SLOT_W-1:0]         tester_slot,
	input  logic [LOC_W-1:0]          loc_x,
	input  logic [LOC_W-1:0]          loc_y,
	input  logic signed [LEVEL_W-1:0] test_level,
	input  logic [PADDR_W-1:0]        pixel_addr,
	input  logic signed [LEVEL_W-1:0] pixel_value,
	input  logic [FERN_W-1:0]         fern_sel,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [FERN_W-1:0]         fern_id,
	input  logic [CODE_W-1:0]         fern_code,
	output int unsigned               mismatches,
	output int unsigned               codes_owed
);

	typedef struct packed {
		logic [FERN_W-1:0] id;
		logic [CODE_W-1:0] code;
	} fern_result_t;

	logic signed [LEVEL_W-1:0] depth_mem [PIXEL_DEPTH];
	tester_t                   tester_mem [TABLE_DEPTH];
	logic [FCNT_W-1:0]         fcnt;
	logic [NDEC_W-1:0]         ndec;
	logic [IMGW_W-1:0]         img_w;
	fern_result_t              codes_due [$];

	function automatic logic [CODE_W-1:0] predict_code(input logic [FERN_W-1:0] fern);
		int unsigned nd;
		int unsigned slot;
		int unsigned addr;
		tester_t t;
		logic [CODE_W-1:0] code;
		code = '0;
		nd = (ndec > MAX_DECISIONS) ? MAX_DECISIONS : ndec;
		if (fern < fcnt) begin
			for (int d = 0; d < nd; d++) begin
				slot = fern * nd + d;
				if (slot < TABLE_DEPTH) begin
					t = tester_mem[slot];
					addr = t.col + t.row * img_w;
					// pixels past the store leave the bit clear
					if (addr < PIXEL_DEPTH && depth_mem[addr] >= t.level)
						code[d] = 1'b1;
				end
			end
		end
		return code;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fern_result_t want;
		if (!arst_n) begin
			fcnt = FERN_COUNT_RST;
			ndec = DECISIONS_RST;
			img_w = IMAGE_WIDTH_RST;
			codes_due.delete();
			mismatches = 0;
			codes_owed = 0;
		end else begin
			// retire before queueing so a same-edge request cannot match itself
			if (out_valid && !out_stall) begin
				if (codes_due.size() == 0) begin
					$error("fern result with nothing owed: fern_id %0d fern_code %0h",
						fern_id, fern_code);
					mismatches++;
				end else begin
					want = codes_due.pop_front();
					if (fern_id !== want.id) begin
						$error("fern_id expected %0d actual %0d", want.id, fern_id);
						mismatches++;
					end
					if (fern_code !== want.code) begin
						$error("fern_code expected %0h actual %0h (fern %0d)",
							want.code, fern_code, want.id);
						mismatches++;
					end
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_FERN_COUNT:  fcnt = cfg_data[FCNT_W-1:0];
					REG_DECISIONS:   ndec = cfg_data[NDEC_W-1:0];
					REG_IMAGE_WIDTH: img_w = cfg_data[IMGW_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (command)
					CMD_TESTER: tester_mem[tester_slot] = '{loc_x, loc_y, test_level};
					CMD_PIXEL:  depth_mem[pixel_addr] = pixel_value;
					CMD_CODE:   codes_due.push_back('{fern_sel, predict_code(fern_sel)});
					default: ;
				endcase
			end
			codes_owed = codes_due.size();
		end
	end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fern code encoder testbench
// Directed tester, pixel and code transactions, then phased random fern
// sequences over several register settings with random idling on both
// channels. Prediction and comparison live in the checker.
// ---------------------------------------------------------------------------
module testbench;
	import rfce_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int PHASE_ITEMS    = 150;
	localparam int PHASE_COUNT    = 11;
	localparam int SETTLE_CYCLES  = 32;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [CMD_W-1:0] command;
	logic [SLOT_W-1:0] tester_slot;
	logic [LOC_W-1:0] loc_x;
	logic [LOC_W-1:0] loc_y;
	logic signed [LEVEL_W-1:0] test_level;
	logic [PADDR_W-1:0] pixel_addr;
	logic signed [LEVEL_W-1:0] pixel_value;
	logic [FERN_W-1:0] fern_sel;
	logic out_valid;
	logic out_stall;
	logic [FERN_W-1:0] fern_id;
	logic [CODE_W-1:0] fern_code;
	int unsigned mismatches;
	int unsigned codes_owed;

	// stimulus bookkeeping: which entries hold data, and where testers point
	bit tester_seen [TABLE_DEPTH];
	bit pixel_seen [PIXEL_DEPTH];
	logic [LOC_W-1:0] tst_col [TABLE_DEPTH];
	logic [LOC_W-1:0] tst_row [TABLE_DEPTH];
	logic signed [LEVEL_W-1:0] tst_lvl [TABLE_DEPTH];
	int unsigned cur_fc;
	int unsigned cur_nd;
	int unsigned cur_w;
	int unsigned issued;
	bit quiet;
	int unsigned idle_cycles;

	always #5 clk = ~clk;

	random_fern_code_encoder DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .tester_slot(tester_slot), .loc_x(loc_x), .loc_y(loc_y),
		.test_level(test_level), .pixel_addr(pixel_addr), .pixel_value(pixel_value),
		.fern_sel(fern_sel),
		.out_valid(out_valid), .out_stall(out_stall),
		.fern_id(fern_id), .fern_code(fern_code)
	);

	fern_code_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .tester_slot(tester_slot), .loc_x(loc_x), .loc_y(loc_y),
		.test_level(test_level), .pixel_addr(pixel_addr), .pixel_value(pixel_value),
		.fern_sel(fern_sel),
		.out_valid(out_valid), .out_stall(out_stall),
		.fern_id(fern_id), .fern_code(fern_code),
		.mismatches(mismatches), .codes_owed(codes_owed)
	);

	function automatic logic signed [LEVEL_W-1:0] rand_level();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3: return '1;
			default: return LEVEL_W'($urandom);
		endcase
	endfunction

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
		input logic [LOC_W-1:0] x, input logic [LOC_W-1:0] y,
		input logic signed [LEVEL_W-1:0] lvl, input logic [PADDR_W-1:0] paddr,
		input logic signed [LEVEL_W-1:0] pval, input logic [FERN_W-1:0] fern);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 11) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		command = cmd;
		tester_slot = slot;
		loc_x = x;
		loc_y = y;
		test_level = lvl;
		pixel_addr = paddr;
		pixel_value = pval;
		fern_sel = fern;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (cmd == CMD_TESTER) begin
			tester_seen[slot] = 1'b1;
			tst_col[slot] = x;
			tst_row[slot] = y;
			tst_lvl[slot] = lvl;
		end else if (cmd == CMD_PIXEL) begin
			pixel_seen[paddr] = 1'b1;
		end
		if (cmd != CMD_UNUSED)
			issued++;
	endtask

	task automatic put_tester(input logic [SLOT_W-1:0] slot, input logic [LOC_W-1:0] x,
		input logic [LOC_W-1:0] y, input logic signed [LEVEL_W-1:0] lvl);
		send_item(CMD_TESTER, slot, x, y, lvl, PADDR_W'($urandom), LEVEL_W'($urandom),
			FERN_W'($urandom));
	endtask

	task automatic put_pixel(input logic [PADDR_W-1:0] addr,
		input logic signed [LEVEL_W-1:0] val);
		send_item(CMD_PIXEL, SLOT_W'($urandom), LOC_W'($urandom), LOC_W'($urandom),
			LEVEL_W'($urandom), addr, val, FERN_W'($urandom));
	endtask

	task automatic ask_code(input logic [FERN_W-1:0] fern);
		send_item(CMD_CODE, SLOT_W'($urandom), LOC_W'($urandom), LOC_W'($urandom),
			LEVEL_W'($urandom), PADDR_W'($urandom), LEVEL_W'($urandom), fern);
	endtask

	// Fill in whatever testers and pixels the fern will read, then request it.
	task automatic fern_sequence();
		int unsigned nd;
		int unsigned lim;
		int unsigned fern;
		int unsigned slot;
		int unsigned addr;
		nd = (cur_nd > MAX_DECISIONS) ? MAX_DECISIONS : cur_nd;
		lim = (cur_fc < MAX_FERNS) ? cur_fc : MAX_FERNS;
		if (lim == 0 || nd == 0 || $urandom_range(0, 9) == 0)
			fern = $urandom_range(0, MAX_FERNS - 1);
		else
			fern = $urandom_range(0, lim - 1);
		if (fern < cur_fc && nd != 0) begin
			for (int d = 0; d < nd; d++) begin
				slot = fern * nd + d;
				if (!tester_seen[slot] || $urandom_range(0, 2) == 0)
					put_tester(SLOT_W'(slot), LOC_W'($urandom), LOC_W'($urandom),
						rand_level());
				addr = tst_col[slot] + tst_row[slot] * cur_w;
				if (addr < PIXEL_DEPTH && (!pixel_seen[addr] || $urandom_range(0, 3) == 0))
					put_pixel(PADDR_W'(addr),
						($urandom_range(0, 3) == 0) ? tst_lvl[slot] : rand_level());
			end
		end
		ask_code(FERN_W'(fern));
	endtask

	task automatic stray_item();
		case ($urandom_range(0, 3))
			0: put_tester(SLOT_W'($urandom), LOC_W'($urandom), LOC_W'($urandom), rand_level());
			1: put_pixel(PADDR_W'($urandom), rand_level());
			2: send_item(CMD_UNUSED, SLOT_W'($urandom), LOC_W'($urandom), LOC_W'($urandom),
				LEVEL_W'($urandom), PADDR_W'($urandom), LEVEL_W'($urandom), FERN_W'($urandom));
			default: begin
				// a fern past the count reads nothing
				if (cur_fc < MAX_FERNS)
					ask_code(FERN_W'($urandom_range(cur_fc, MAX_FERNS - 1)));
				else
					fern_sequence();
			end
		endcase
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (codes_owed != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apply_setting(input logic [FCNT_W-1:0] fc, input logic [NDEC_W-1:0] nd,
		input logic [IMGW_W-1:0] w);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = REG_FERN_COUNT;
		cfg_data = fc;
		@(negedge clk);
		cfg_index = REG_DECISIONS;
		cfg_data = {6'($urandom), nd};
		@(negedge clk);
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = {2'($urandom), w};
		@(negedge clk);
		cfg_write = 1'b0;
		cur_fc = fc;
		cur_nd = nd;
		cur_w = w;
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int unsigned goal;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = '0;
		tester_slot = '0;
		loc_x = '0;
		loc_y = '0;
		test_level = '0;
		pixel_addr = '0;
		pixel_value = '0;
		fern_sel = '0;
		quiet = 1'b0;
		issued = 0;
		cur_fc = FERN_COUNT_RST;
		cur_nd = DECISIONS_RST;
		cur_w = IMAGE_WIDTH_RST;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// reset settings: four decisions, width 80, 500 ferns
		put_tester(0, 0, 0, 16'sh8000);
		put_tester(1, 127, 127, 16'sh7fff);
		put_tester(2, 5, 1, 0);
		put_tester(3, 5, 1, 1);
		put_pixel(0, 16'sh8000);
		put_pixel(10287, 16'sh7fff);
		put_pixel(85, 0);
		ask_code(0);
		put_pixel(10287, 16'sh7ffe);
		put_pixel(0, 16'sh7fff);
		put_pixel(85, 1);
		ask_code(0);
		ask_code(511);
		ask_code(500);
		ask_code(499 - 499);
		send_item(CMD_UNUSED, '1, '1, '1, '1, '1, '1, '1);
		put_tester(4095, 127, 127, -1);
		put_pixel(16383, 16'sh7fff);
		put_pixel(0, '0);
		ask_code(0);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			wait_idle();
			case (p)
				0: apply_setting(1, 1, 1);
				1: apply_setting(512, 8, 128);
				2: apply_setting(0, 3, 64);
				3: apply_setting(37, 0, 100);
				4: apply_setting(300, 12, 128);
				5: apply_setting(512, 15, 255);
				6: apply_setting(64, 5, 0);
				7: apply_setting(1023, 8, 37);
				8: apply_setting(FCNT_W'($urandom_range(1, 512)),
					NDEC_W'($urandom_range(1, 8)), IMGW_W'($urandom_range(1, 128)));
				9: apply_setting(FCNT_W'($urandom_range(0, 1023)),
					NDEC_W'($urandom_range(0, 15)), IMGW_W'($urandom_range(0, 255)));
				default: apply_setting(200, 2, 128);
			endcase
			quiet = (p == PHASE_COUNT - 1);
			goal = issued + PHASE_ITEMS;
			while (issued < goal) begin
				if ($urandom_range(0, 4) == 0)
					stray_item();
				else
					fern_sequence();
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && codes_owed == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
